>>> rtl/ccd_pkg.sv
// Package: shared types and constants of the compressed coefficient decoder.
package ccd_pkg;

  localparam logic [3:0]  LOG_COUNT_RESET = 4'd9;
  localparam logic [11:0] UNARY_STEP      = 12'd128;
  localparam logic [6:0]  LOW_MASK        = 7'd127;
  localparam logic [11:0] MAG_MAX         = 12'd2047;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EXHAUSTED  = 3'd1,
    ERR_MAGNITUDE  = 3'd2,
    ERR_MINUS_ZERO = 3'd3,
    ERR_PADDING    = 3'd4
  } ccd_err_t;

  // Bit-level decode state carried between bytes.
  typedef struct packed {
    logic [7:0]  pending_bits;
    logic [2:0]  pending_count;
    logic        in_unary_phase;
    logic        sign_bit;
    logic [10:0] magnitude;
  } ccd_state_t;

  // What one byte produces.
  typedef struct packed {
    logic               coef_valid;
    logic signed [11:0] coef_value;
    logic [9:0]         coef_index;
    logic               frame_done;
    ccd_err_t           error_kind;
  } ccd_result_t;

endpackage

>>> rtl/ccd_if.sv
// Interfaces: byte stream channel and coefficient result channel.
interface ccd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ccd_out_if;
  logic               valid;
  logic               ready;
  logic               coef_valid;
  logic signed [11:0] coef_value;
  logic [9:0]         coef_index;
  logic               frame_done;
  logic [2:0]         error_kind;
  logic [11:0]        bytes_used;
  modport source (output valid, output coef_valid, output coef_value, output coef_index,
                  output frame_done, output error_kind, output bytes_used, input ready);
  modport sink   (input valid, input coef_valid, input coef_value, input coef_index,
                  input frame_done, input error_kind, input bytes_used, output ready);
endinterface

>>> rtl/compressed_coefficient_decoder_top.sv
// Top level: compressed coefficient decoder with input and result registers.
// The block takes one compressed byte per item on stream and gives one result item per byte
// on result, one item per clock sustained while result.ready stays high. A byte accepted is
// held in the input register, decoded from there, and its result item is registered in the
// result register when that stage advances. The rate is set by the byte decoder, which walks
// the eight bits of a registered byte combinationally and updates the decode state at the
// same edge as the result register. While a result item waits, the input register holds one
// more byte and then stream.ready drops. At most one coefficient completes per byte.
// A result carries the coefficient (when coef_valid), frame_done with bytes_used at the end
// of a frame, or an error code; after either the next byte begins a new frame. log_count
// is written through cfg_we and cfg_data; the user must write it only while the block is
// idle, as the block does not enforce this. Values above MAX_LOG_COUNT are clamped. No
// clearing pass is needed after reset.
module compressed_coefficient_decoder_top #(
  parameter int MAX_LOG_COUNT = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_data,
  ccd_in_if.sink          stream,
  ccd_out_if.source       result
);
  import ccd_pkg::*;

  // Coefficient counter holds up to the frame length itself.
  localparam int CNT_W = MAX_LOG_COUNT + 1;

  logic [3:0]       log_count;

  // input register
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;

  // decode state
  ccd_state_t       state;
  logic [CNT_W-1:0] coef_counter;
  logic [11:0]      byte_counter;

  // result register
  logic             out_valid;
  ccd_result_t      out_res;
  logic [11:0]      out_used;

  ccd_state_t       state_next;
  logic [CNT_W-1:0] coef_counter_next;
  logic [11:0]      byte_counter_next;
  logic [11:0]      byte_inc;
  logic [11:0]      used_next;
  ccd_result_t      res_next;
  logic [3:0]       lg;
  logic [CNT_W-1:0] frame_len;
  logic             advance;

  // result stage moves when empty or being taken; input stage follows it
  assign advance      = !out_valid || result.ready;
  assign stream.ready = !s1_valid || advance;

  assign lg        = (log_count > 4'(MAX_LOG_COUNT)) ? 4'(MAX_LOG_COUNT) : log_count;
  assign frame_len = CNT_W'(1) << lg;

  ccd_byte_decode #(.CNT_W(CNT_W)) u_decode (
    .state_in  (state),
    .count_in  (coef_counter),
    .frame_len (frame_len),
    .in_byte   (s1_byte),
    .in_last   (s1_last),
    .state_out (state_next),
    .count_out (coef_counter_next),
    .res       (res_next)
  );

  // byte count includes the current byte; cleared together with the decode state
  assign byte_inc  = byte_counter + 12'd1;
  assign used_next = res_next.frame_done ? byte_inc : 12'd0;
  assign byte_counter_next =
    (res_next.frame_done || res_next.error_kind != ERR_NONE) ? 12'd0 : byte_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_count <= LOG_COUNT_RESET;
    end else if (cfg_we) begin
      log_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_byte <= stream.in_byte;
      s1_last <= stream.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      coef_counter <= '0;
      byte_counter <= '0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        state        <= state_next;
        coef_counter <= coef_counter_next;
        byte_counter <= byte_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_res  <= res_next;
      out_used <= used_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.coef_valid = out_res.coef_valid;
  assign result.coef_value = out_res.coef_value;
  assign result.coef_index = out_res.coef_index;
  assign result.frame_done = out_res.frame_done;
  assign result.error_kind = out_res.error_kind;
  assign result.bytes_used = out_used;

endmodule

>>> rtl/ccd_byte_decode.sv
// Byte decoder: scans the eight bits of one byte through the coefficient grammar.
module ccd_byte_decode #(
  parameter int CNT_W = 11
) (
  input  ccd_pkg::ccd_state_t  state_in,
  input  logic [CNT_W-1:0]     count_in,
  input  logic [CNT_W-1:0]     frame_len,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output ccd_pkg::ccd_state_t  state_out,
  output logic [CNT_W-1:0]     count_out,
  output ccd_pkg::ccd_result_t res
);
  import ccd_pkg::*;

  always_comb begin
    ccd_state_t       st;
    logic [CNT_W-1:0] cnt;
    logic [10:0]      cnt_ext;
    logic [11:0]      mag_sum;
    logic             active;
    logic             b;
    st      = state_in;
    cnt     = count_in;
    cnt_ext = '0;
    mag_sum = '0;
    active  = 1'b1;
    b       = 1'b0;
    res     = '0;
    res.error_kind = ERR_NONE;
    for (int k = 0; k < 8; k++) begin
      b = in_byte[7-k];
      if (active) begin
        if (!st.in_unary_phase) begin
          st.pending_bits = {st.pending_bits[6:0], b};
          if (st.pending_count == 3'd7) begin
            st.sign_bit       = st.pending_bits[7];
            st.magnitude      = {4'd0, st.pending_bits[6:0] & LOW_MASK};
            st.pending_count  = 3'd0;
            st.pending_bits   = 8'd0;
            st.in_unary_phase = 1'b1;
          end else begin
            st.pending_count = st.pending_count + 3'd1;
          end
        end else if (!b) begin
          mag_sum      = {1'b0, st.magnitude} + UNARY_STEP;
          st.magnitude = mag_sum[10:0];
          if (mag_sum > MAG_MAX) begin
            res.error_kind = ERR_MAGNITUDE;
            active         = 1'b0;
          end
        end else if (st.sign_bit && st.magnitude == 11'd0) begin
          res.error_kind = ERR_MINUS_ZERO;
          active         = 1'b0;
        end else begin
          cnt_ext        = 11'(cnt);
          res.coef_valid = 1'b1;
          res.coef_index = cnt_ext[9:0];
          res.coef_value = st.sign_bit ? 12'sd0 - $signed({1'b0, st.magnitude})
                                       : $signed({1'b0, st.magnitude});
          cnt               = cnt + CNT_W'(1);
          st.in_unary_phase = 1'b0;
          st.sign_bit       = 1'b0;
          st.magnitude      = 11'd0;
          if (cnt >= frame_len) begin
            active = 1'b0;
            // bits after the final terminator must be zero
            if ((in_byte & (8'hFF >> (k + 1))) != 8'd0) begin
              res.error_kind = ERR_PADDING;
            end else begin
              res.frame_done = 1'b1;
            end
          end
        end
      end
    end
    if (res.error_kind == ERR_NONE && !res.frame_done && in_last) begin
      res.error_kind = ERR_EXHAUSTED;
    end
    if (res.error_kind != ERR_NONE || res.frame_done) begin
      st  = '0;
      cnt = '0;
    end
    state_out = st;
    count_out = cnt;
  end

endmodule

>>> rtl/ccd_checker.sv
// Checker: port-level properties of the decoder, bound to the top level.
module ccd_checker (
  input logic               clk,
  input logic               rst,
  input logic               r_valid,
  input logic               r_ready,
  input logic               coef_valid,
  input logic signed [11:0] coef_value,
  input logic [9:0]         coef_index,
  input logic               frame_done,
  input logic [2:0]         error_kind,
  input logic [11:0]        bytes_used
);
  import ccd_pkg::*;

  // a frame ends only on a terminator bit and never together with an error
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    r_valid && frame_done |-> coef_valid && error_kind == ERR_NONE)
    else $error("frame_done with error or without coefficient");

  a_used_only_done: assert property (@(posedge clk) disable iff (rst)
    r_valid && !frame_done |-> bytes_used == 12'd0)
    else $error("bytes_used outside frame_done");

  a_idle_coef_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && !coef_valid |-> coef_value == 12'sd0 && coef_index == 10'd0)
    else $error("coefficient fields set without coef_valid");

  // a completed coefficient needs nine bits, so no unary error can follow in the same byte
  a_no_unary_err: assert property (@(posedge clk) disable iff (rst)
    r_valid && coef_valid |-> error_kind != ERR_MAGNITUDE && error_kind != ERR_MINUS_ZERO)
    else $error("coefficient and unary error in one byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(coef_valid) && $stable(coef_value)
      && $stable(coef_index) && $stable(frame_done) && $stable(error_kind)
      && $stable(bytes_used))
    else $error("stalled result item changed");

endmodule

bind compressed_coefficient_decoder_top ccd_checker u_ccd_checker (
  .clk        (clk),
  .rst        (rst),
  .r_valid    (result.valid),
  .r_ready    (result.ready),
  .coef_valid (result.coef_valid),
  .coef_value (result.coef_value),
  .coef_index (result.coef_index),
  .frame_done (result.frame_done),
  .error_kind (result.error_kind),
  .bytes_used (result.bytes_used)
);

>>> test/compressed_coefficient_decoder_top_tb.sv
// Testbench for the compressed coefficient decoder: byte stream in, checked results out.
`timescale 1ns / 100ps

module compressed_coefficient_decoder_top_tb;
  import ccd_pkg::*;

  localparam int MAX_LOG  = 10;
  localparam int STALL_CAP = 3000;   // cycles with no item moving either way
  localparam int HOLD_LEN  = 400;    // long receiver hold-off, fills the block

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // Expected content of one result item.
  typedef struct packed {
    logic               cv;
    logic signed [11:0] val;
    logic [9:0]         idx;
    logic               done;
    ccd_err_t           err;
    logic [11:0]        used;
  } dec_result_t;

  // How a generated frame is spoilt, if at all.
  typedef enum int {
    FRAME_CLEAN,
    FRAME_MINUS_ZERO,
    FRAME_TOO_LARGE,
    FRAME_BAD_PAD,
    FRAME_CUT
  } frame_fault_t;

  // What fills the spare bits of the final byte.
  typedef enum int {
    PAD_ZERO,
    PAD_DIRTY,
    PAD_ANY
  } pad_fill_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_data;

  ccd_in_if  byte_ch ();
  ccd_out_if res_ch ();

  compressed_coefficient_decoder_top #(.MAX_LOG_COUNT(MAX_LOG)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .stream(byte_ch),
    .result(res_ch)
  );

  always #4 clk = ~clk;

  // Bytes waiting to be offered, and results owed by the block, oldest first.
  stream_byte_t feed_q[$];
  dec_result_t  coef_results_due[$];
  bit           bit_buf[$];     // bit stream of the frame under construction
  int           bytes_queued;
  int           results_taken;
  int           fault_count;

  // Own copy of the decoder state and of log_count.
  logic [7:0]  hdr_bits;
  logic [2:0]  hdr_count;
  logic        in_unary;
  logic        neg;
  logic [11:0] mag_acc;
  logic [10:0] coefs_done;
  logic [11:0] frame_bytes;
  logic [3:0]  log_sel;

  function automatic void clear_frame();
    hdr_bits    = '0;
    hdr_count   = '0;
    in_unary    = 1'b0;
    neg         = 1'b0;
    mag_acc     = '0;
    coefs_done  = '0;
    frame_bytes = '0;
  endfunction

  // Walks the eight bits of one byte, MSB first, and returns the result it gives.
  function automatic dec_result_t decode_byte(input logic [7:0] b, input logic lst);
    dec_result_t r;
    logic [3:0]  lg;
    logic [10:0] frame_len;
    logic [7:0]  low_mask;
    logic        fin;
    int          k;
    r   = '0;
    fin = 1'b0;
    r.err = ERR_NONE;
    lg = (log_sel > MAX_LOG) ? 4'(MAX_LOG) : log_sel;
    frame_len = 11'd1 << lg;
    frame_bytes = frame_bytes + 12'd1;
    for (k = 7; k >= 0; k--) begin
      if (r.err == ERR_NONE && !fin) begin
        if (!in_unary) begin
          hdr_bits = {hdr_bits[6:0], b[k]};
          if (hdr_count == 3'd7) begin
            neg       = hdr_bits[7];
            mag_acc   = {5'd0, hdr_bits[6:0]};
            hdr_count = '0;
            hdr_bits  = '0;
            in_unary  = 1'b1;
          end else begin
            hdr_count = hdr_count + 3'd1;
          end
        end else if (!b[k]) begin
          mag_acc = mag_acc + UNARY_STEP;
          if (mag_acc > MAG_MAX) r.err = ERR_MAGNITUDE;
        end else if (neg && mag_acc == 0) begin
          r.err = ERR_MINUS_ZERO;
        end else begin
          r.cv  = 1'b1;
          r.idx = coefs_done[9:0];
          r.val = neg ? 12'd0 - mag_acc : mag_acc;
          coefs_done = coefs_done + 11'd1;
          in_unary = 1'b0;
          neg      = 1'b0;
          mag_acc  = '0;
          if (coefs_done >= frame_len) begin
            // bits after the last coefficient must all be zero
            low_mask = (8'd1 << k) - 8'd1;
            if ((b & low_mask) != 0) r.err = ERR_PADDING;
            else fin = 1'b1;
          end
        end
      end
    end
    if (r.err == ERR_NONE && !fin && lst) r.err = ERR_EXHAUSTED;
    r.done = fin;
    if (fin) r.used = frame_bytes;
    if (r.err != ERR_NONE || fin) clear_frame();
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] d, input logic lst);
    stream_byte_t it;
    it.data = d;
    it.last = lst;
    feed_q.push_back(it);
    bytes_queued++;
  endtask

  // Sign, seven low bits, one zero per 128, closing one. Oversized
  // magnitudes leave the closing one out: the block stops on the zeros.
  task automatic add_coef(input bit sg, input int unsigned m);
    int i;
    bit_buf.push_back(sg);
    for (i = 6; i >= 0; i--) bit_buf.push_back(m[i]);
    for (i = 0; i < (m >> 7); i++) bit_buf.push_back(1'b0);
    if (m <= MAG_MAX) bit_buf.push_back(1'b1);
  endtask

  // Pads the bit stream to whole bytes and queues them. A cut frame stops
  // short of its final byte and flags the last one it keeps.
  task automatic emit_bits(input pad_fill_t fill, input bit cut, input bit last_end);
    int         nbytes, keep, i, j, npad;
    bit         pb;
    logic [7:0] cur;
    npad = 0;
    while (bit_buf.size() % 8 != 0) begin
      pb = (fill == PAD_ZERO) ? 1'b0 : 1'($urandom_range(0, 1));
      bit_buf.push_back(pb);
      npad++;
    end
    if (fill == PAD_DIRTY && npad > 0) bit_buf[bit_buf.size() - 1] = 1'b1;
    nbytes = bit_buf.size() / 8;
    keep = (cut && nbytes > 1) ? $urandom_range(1, nbytes - 1) : nbytes;
    for (i = 0; i < keep; i++) begin
      for (j = 0; j < 8; j++) cur[7 - j] = bit_buf[8 * i + j];
      push_byte(cur, (i == keep - 1) ? (last_end || cut) : 1'b0);
    end
    bit_buf.delete();
  endtask

  function automatic int pick_mag(input bit narrow);
    int m;
    if (narrow) begin
      m = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 127);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: m = $urandom_range(0, 127);
        6, 7:             m = $urandom_range(128, 511);
        8:                m = $urandom_range(512, 2047);
        default: begin
          case ($urandom_range(0, 3))
            0:       m = 0;
            1:       m = 127;
            2:       m = 128;
            default: m = 2047;
          endcase
        end
      endcase
    end
    return m;
  endfunction

  // One frame of ncoef coefficients, now and then spoilt on purpose.
  task automatic gen_frame(input int ncoef, input bit narrow);
    frame_fault_t fault;
    int           spot, i, m, roll;
    bit           sg, stop;
    roll = $urandom_range(0, 9);
    if (narrow || roll < 6) fault = FRAME_CLEAN;
    else if (roll == 6)     fault = FRAME_MINUS_ZERO;
    else if (roll == 7)     fault = FRAME_TOO_LARGE;
    else if (roll == 8)     fault = FRAME_BAD_PAD;
    else                    fault = FRAME_CUT;
    spot = $urandom_range(0, ncoef - 1);
    stop = 1'b0;
    for (i = 0; i < ncoef && !stop; i++) begin
      if (i == spot && fault == FRAME_MINUS_ZERO) begin
        add_coef(1'b1, 0);
        stop = 1'b1;
      end else if (i == spot && fault == FRAME_TOO_LARGE) begin
        sg = $urandom_range(0, 1);
        add_coef(sg, 2048 + $urandom_range(0, 127));
        stop = 1'b1;
      end else begin
        m  = pick_mag(narrow);
        sg = (m == 0) ? 1'b0 : 1'($urandom_range(0, 1));
        add_coef(sg, m);
      end
    end
    case (fault)
      FRAME_MINUS_ZERO, FRAME_TOO_LARGE: emit_bits(PAD_ANY, 1'b0, $urandom_range(0, 3) == 0);
      FRAME_BAD_PAD: emit_bits(PAD_DIRTY, 1'b0, $urandom_range(0, 3) == 0);
      FRAME_CUT:     emit_bits(PAD_ZERO, 1'b1, 1'b1);
      default:       emit_bits(PAD_ZERO, 1'b0, $urandom_range(0, 3) == 0);
    endcase
  endtask

  task automatic add_noise(input int count);
    int i;
    for (i = 0; i < count; i++) push_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0);
  endtask

  task automatic fill_random(input logic [3:0] lg, input int budget);
    int start, nco;
    nco = 1 << ((lg > MAX_LOG) ? MAX_LOG : lg);
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      if ($urandom_range(0, 6) == 0) add_noise($urandom_range(1, 4));
      else gen_frame(nco, 1'b0);
    end
  endtask

  // Idle means nothing queued, nothing offered, nothing owed; checked at the
  // falling edge so the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (feed_q.size() != 0 || byte_ch.valid || coef_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_log(input logic [3:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    log_sel = v;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.in_byte = '0;
    byte_ch.in_last = 1'b0;
    res_ch.ready = 1'b0;
    bytes_queued = 0;
    results_taken = 0;
    fault_count = 0;
    clear_frame();
    log_sel = LOG_COUNT_RESET;

    // reset value of log_count: a frame of 512 never completes, so plain noise
    add_noise(40);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed items, one coefficient per frame
    write_log(4'd0);
    add_coef(1'b0, 0);      emit_bits(PAD_ZERO, 1'b0, 1'b0);   // plus zero
    add_coef(1'b0, 127);    emit_bits(PAD_ZERO, 1'b0, 1'b1);   // last flag on the final byte
    add_coef(1'b1, 127);    emit_bits(PAD_ZERO, 1'b0, 1'b0);   // all-ones header
    add_coef(1'b1, 128);    emit_bits(PAD_ZERO, 1'b0, 1'b0);   // one unary step
    add_coef(1'b0, 2047);   emit_bits(PAD_ZERO, 1'b0, 1'b0);   // largest magnitude
    add_coef(1'b1, 2047);   emit_bits(PAD_ZERO, 1'b0, 1'b0);
    add_coef(1'b0, 1023);   emit_bits(PAD_ZERO, 1'b0, 1'b0);   // ends on bit 0, no padding
    add_coef(1'b1, 0);      emit_bits(PAD_ANY, 1'b0, 1'b0);    // minus zero
    add_coef(1'b1, 2175);   emit_bits(PAD_ANY, 1'b0, 1'b0);    // magnitude over the limit
    add_coef(1'b1, 1);      emit_bits(PAD_DIRTY, 1'b0, 1'b0);  // coefficient with bad padding
    push_byte(8'hA5, 1'b1);                                     // input runs out in the header
    fill_random(4'd0, 80);

    write_log(4'd1);  fill_random(4'd1, 100);
    write_log(4'd2);  fill_random(4'd2, 100);
    write_log(4'd3);  fill_random(4'd3, 100);
    write_log(4'd5);  fill_random(4'd5, 120);

    // above the maximum: clamped to 1024 coefficients, one long frame
    write_log(4'd15);
    gen_frame(1 << MAX_LOG, 1'b1);
    add_noise(6);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("compressed_coefficient_decoder_top_tb: PASS");
    end else begin
      $display("compressed_coefficient_decoder_top_tb: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  // Offers queued bytes in bursts of random length with random gaps; a gap
  // of zero runs bursts together. Each accepted item is predicted at once.

  stream_byte_t feed_head;
  int           burst_left;
  int           gap_left;

  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready)
        coef_results_due.push_back(decode_byte(byte_ch.in_byte, byte_ch.in_last));
      if (!byte_ch.valid || byte_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_ch.valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          feed_head = feed_q.pop_front();
          byte_ch.valid   <= 1'b1;
          byte_ch.in_byte <= feed_head.data;
          byte_ch.in_last <= feed_head.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  // Ready follows a mode that is picked afresh periodically. Once, part way
  // through the long frame, ready is held low long enough for the block
  // to fill and push back on the byte stream.

  int rx_mode;
  int rx_tick;
  int hold_left;
  bit long_hold_done;

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      fault_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  dec_result_t due;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_mode   = 0;
      rx_tick   = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_taken++;
        if (coef_results_due.size() == 0) begin
          fault_count++;
          $display("%0t ns: result item with none expected, coef_value %0d error_kind %0d",
                   $time, res_ch.coef_value, res_ch.error_kind);
        end else begin
          due = coef_results_due.pop_front();
          check_field("coef_valid", due.cv, res_ch.coef_valid);
          check_field("coef_value", due.val, res_ch.coef_value);
          check_field("coef_index", due.idx, res_ch.coef_index);
          check_field("frame_done", due.done, res_ch.frame_done);
          check_field("error_kind", due.err, res_ch.error_kind);
          check_field("bytes_used", due.used, res_ch.bytes_used);
        end
      end

      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_taken >= 900) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_LEN;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= (rx_tick % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  // Counts cycles in which no item moves on either side.

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_CAP) begin
        $display("%0t ns: no item moved for %0d cycles", $time, STALL_CAP);
        $display("compressed_coefficient_decoder_top_tb: FAIL");
        $finish;
      end
    end
  end

endmodule
